// ===== src/bpc_pkg.sv =====
package bpc_pkg;

	localparam int COUNT_BITS_DEF = 10;
	localparam int TICK_W = 10;
	localparam int CFG_IDX_W = 3;
	localparam logic [TICK_W-1:0] HELD_MAX = '1;

	localparam logic [TICK_W-1:0] DEBOUNCE_RST = 10'd4;
	localparam logic [TICK_W-1:0] PROGRESS_RST = 10'd25;
	localparam logic [TICK_W-1:0] LONG_HOLD_RST = 10'd150;
	localparam logic [TICK_W-1:0] RELEASE_RST = 10'd12;
	localparam logic [TICK_W-1:0] LOCKOUT_RST = 10'd40;
	localparam logic [TICK_W-1:0] BLANK_RST = 10'd6;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_DEBOUNCE  = 3'd0,
		CFG_PROGRESS  = 3'd1,
		CFG_LONG_HOLD = 3'd2,
		CFG_RELEASE   = 3'd3,
		CFG_LOCKOUT   = 3'd4,
		CFG_BLANK     = 3'd5
	} cfg_idx_t;

	typedef enum logic [1:0] {
		PH_IDLE    = 2'd0,
		PH_PRESSED = 2'd1,
		PH_WAIT    = 2'd2,
		PH_BLANK   = 2'd3
	} phase_t;

	typedef enum logic [3:0] {
		EV_NONE      = 4'd0,
		EV_POWER_ON  = 4'd1,
		EV_POWER_OFF = 4'd2,
		EV_CAPTURE   = 4'd3,
		EV_LOCKOUT   = 4'd4,
		EV_OFF       = 4'd5,
		EV_NOCONN    = 4'd6,
		EV_NOTREADY  = 4'd7,
		EV_BOUNCE    = 4'd8
	} event_t;

	typedef enum logic [1:0] {
		PROG_NONE  = 2'd0,
		PROG_FILL  = 2'd1,
		PROG_DRAIN = 2'd2
	} prog_t;

	typedef enum logic [1:0] {
		COLOR_OFF   = 2'd0,
		COLOR_WHITE = 2'd1,
		COLOR_BLUE  = 2'd2
	} color_t;

	typedef struct packed {
		logic button_pressed;
		logic link_connected;
		logic receiver_ready;
	} in_word_t;

	typedef struct packed {
		logic [3:0]        event_code;
		logic              power_on;
		logic [1:0]        progress_mode;
		logic [TICK_W-1:0] held_count;
		logic [1:0]        status_color;
	} out_word_t;

	typedef struct packed {
		logic [TICK_W-1:0] debounce_ticks;
		logic [TICK_W-1:0] progress_ticks;
		logic [TICK_W-1:0] long_hold_ticks;
		logic [TICK_W-1:0] release_ticks;
		logic [TICK_W-1:0] lockout_ticks;
		logic [TICK_W-1:0] blank_ticks;
	} cfg_t;

endpackage

// ===== src/bpc_core.sv =====
module bpc_core #(
	parameter int COUNT_BITS = bpc_pkg::COUNT_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               step,
	input  bpc_pkg::in_word_t  in_word,
	input  bpc_pkg::cfg_t      cfg,
	output bpc_pkg::out_word_t res
);
	import bpc_pkg::*;

	localparam int CMP_W = (COUNT_BITS > TICK_W) ? COUNT_BITS : TICK_W;
	localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;
	localparam logic [CMP_W-1:0] CNT_MAX_X = CMP_W'(CNT_MAX);
	localparam logic [CMP_W-1:0] HELD_MAX_X = CMP_W'(HELD_MAX);

	phase_t                phase_q, phase_d, end_phase;
	logic                  power_q, power_d;
	logic [COUNT_BITS-1:0] hold_q, hold_d, rel_q, rel_d, lock_q, lock_d, blank_q, blank_d;
	logic [COUNT_BITS-1:0] lock_dec, hold_inc, judge_val, blank_dec, blank_load;
	logic                  btn, prog_hit, long_hit, short_bounce, rel_done, do_judge;
	logic [CMP_W-1:0]      held_x;
	event_t                ev;
	prog_t                 prog;

	function automatic logic [COUNT_BITS-1:0] sat_load(input logic [TICK_W-1:0] v);
		logic [CMP_W-1:0] vx;
		vx = CMP_W'(v);
		sat_load = (vx > CNT_MAX_X) ? CNT_MAX : vx[COUNT_BITS-1:0];
	endfunction

	always_comb begin
		btn          = in_word.button_pressed;
		lock_dec     = (lock_q != '0) ? lock_q - COUNT_BITS'(1) : lock_q;
		hold_inc     = (hold_q != CNT_MAX) ? hold_q + COUNT_BITS'(1) : hold_q;
		blank_dec    = (blank_q != '0) ? blank_q - COUNT_BITS'(1) : blank_q;
		judge_val    = (phase_q == PH_IDLE) ? '0 : hold_inc;
		prog_hit     = CMP_W'(judge_val) >= CMP_W'(cfg.progress_ticks);
		long_hit     = CMP_W'(judge_val) >= CMP_W'(cfg.long_hold_ticks);
		short_bounce = CMP_W'(hold_inc) < CMP_W'(cfg.debounce_ticks);
		rel_done     = CMP_W'(rel_q) >= CMP_W'(cfg.release_ticks);
		end_phase    = (cfg.blank_ticks == '0) ? PH_IDLE : PH_BLANK;
		blank_load   = (cfg.blank_ticks == '0) ? '0 : sat_load(cfg.blank_ticks);
		do_judge     = btn && (phase_q == PH_IDLE || phase_q == PH_PRESSED);
	end

	// next phase
	always_comb begin
		phase_d = phase_q;
		unique case (phase_q)
			PH_IDLE: begin
				if (btn) begin
					phase_d = long_hit ? PH_WAIT : PH_PRESSED;
				end
			end
			PH_PRESSED: begin
				if (btn) begin
					phase_d = long_hit ? PH_WAIT : PH_PRESSED;
				end else begin
					phase_d = end_phase;
				end
			end
			PH_WAIT: begin
				if (!btn && rel_done) begin
					phase_d = end_phase;
				end
			end
			PH_BLANK: begin
				if (blank_dec == '0) begin
					phase_d = PH_IDLE;
				end
			end
			default: phase_d = PH_IDLE;
		endcase
	end

	// counters and result
	always_comb begin
		power_d = power_q;
		hold_d  = hold_q;
		rel_d   = rel_q;
		lock_d  = lock_dec;
		blank_d = blank_q;
		ev      = EV_NONE;
		prog    = PROG_NONE;
		unique case (phase_q)
			PH_IDLE: begin
				if (btn) begin
					hold_d = '0;
				end
			end
			PH_PRESSED: begin
				hold_d = hold_inc;
				if (!btn) begin
					blank_d = blank_load;
					if (short_bounce) begin
						ev = EV_BOUNCE;
					end else if (lock_dec != '0) begin
						ev = EV_LOCKOUT;
					end else if (!power_q) begin
						ev = EV_OFF;
					end else if (!in_word.link_connected) begin
						ev = EV_NOCONN;
					end else if (!in_word.receiver_ready) begin
						ev = EV_NOTREADY;
					end else begin
						ev = EV_CAPTURE;
					end
				end
			end
			PH_WAIT: begin
				if (btn) begin
					rel_d = '0;
				end else if (rel_done) begin
					lock_d  = sat_load(cfg.lockout_ticks);
					blank_d = blank_load;
				end else if (rel_q != CNT_MAX) begin
					rel_d = rel_q + COUNT_BITS'(1);
				end
			end
			PH_BLANK: begin
				blank_d = blank_dec;
			end
			default: blank_d = blank_q;
		endcase
		if (do_judge) begin
			if (prog_hit) begin
				prog = power_q ? PROG_DRAIN : PROG_FILL;
			end
			if (long_hit) begin
				power_d = !power_q;
				ev      = power_q ? EV_POWER_OFF : EV_POWER_ON;
				rel_d   = '0;
			end
		end
		held_x            = CMP_W'(hold_d);
		res.event_code    = ev;
		res.power_on      = power_d;
		res.progress_mode = prog;
		res.held_count    = (held_x > HELD_MAX_X) ? HELD_MAX : held_x[TICK_W-1:0];
		res.status_color  = power_d ? (in_word.link_connected ? COLOR_BLUE : COLOR_WHITE)
		                            : COLOR_OFF;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			power_q <= 1'b0;
			hold_q  <= '0;
			rel_q   <= '0;
			lock_q  <= '0;
			blank_q <= '0;
		end else if (step) begin
			phase_q <= phase_d;
			power_q <= power_d;
			hold_q  <= hold_d;
			rel_q   <= rel_d;
			lock_q  <= lock_d;
			blank_q <= blank_d;
		end
	end

endmodule

// ===== src/button_press_power_controller.sv =====
// Button press power controller.
// in channel: one word per poll tick (button level, link connected, receiver
// ready), accepted when in_valid and in_ready are both high.
// out channel: one result word per input word, in order: event code, power
// state after the tick, progress mode, press length and status color.
// cfg channel: cfg_index selects a timing register (debounce, progress, long
// hold, release, lockout, blank), cfg_data is written when cfg_valid is high;
// cfg_ready is always high. Unknown indexes are dropped. Write only while idle.
// The result is registered and appears on out in the cycle after its input word is taken.
// Throughput: one word per cycle unless out stalls; the tick logic sits
// between the state registers and a single result register.
// Stall: while out_ready is held low by a busy receiver the result register
// stays full and in_ready drops until the word is taken; taking the result
// and a new input in the same cycle is supported.
// Reset: power off, idle, all counters zero, timing registers at defaults,
// output register empty.
module button_press_power_controller #(
	parameter int COUNT_BITS = bpc_pkg::COUNT_BITS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  bpc_pkg::in_word_t                in_data,
	output logic                             out_valid,
	input  logic                             out_ready,
	output bpc_pkg::out_word_t               out_data,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [bpc_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [bpc_pkg::TICK_W-1:0]       cfg_data
);
	import bpc_pkg::*;

	cfg_t      cfg_q;
	out_word_t res, res_q;
	logic      res_valid_q, step;

	assign in_ready  = !res_valid_q || out_ready;
	assign step      = in_valid && in_ready;
	assign cfg_ready = 1'b1;
	assign out_valid = res_valid_q;
	assign out_data  = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.debounce_ticks  <= DEBOUNCE_RST;
			cfg_q.progress_ticks  <= PROGRESS_RST;
			cfg_q.long_hold_ticks <= LONG_HOLD_RST;
			cfg_q.release_ticks   <= RELEASE_RST;
			cfg_q.lockout_ticks   <= LOCKOUT_RST;
			cfg_q.blank_ticks     <= BLANK_RST;
		end else if (cfg_valid) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_DEBOUNCE:  cfg_q.debounce_ticks  <= cfg_data;
				CFG_PROGRESS:  cfg_q.progress_ticks  <= cfg_data;
				CFG_LONG_HOLD: cfg_q.long_hold_ticks <= cfg_data;
				CFG_RELEASE:   cfg_q.release_ticks   <= cfg_data;
				CFG_LOCKOUT:   cfg_q.lockout_ticks   <= cfg_data;
				CFG_BLANK:     cfg_q.blank_ticks     <= cfg_data;
				default:       cfg_q <= cfg_q;
			endcase
		end
	end

	bpc_core #(
		.COUNT_BITS(COUNT_BITS)
	) u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (step),
		.in_word (in_data),
		.cfg     (cfg_q),
		.res     (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (in_ready) begin
			res_valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			res_q <= res;
		end
	end

endmodule

// ===== src/bpc_checker.sv =====
module bpc_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          in_valid,
	input logic                          in_ready,
	input logic                          out_valid,
	input logic                          out_ready,
	input bpc_pkg::out_word_t            out_data
);
	import bpc_pkg::*;

	// a stalled result stays put
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result word dropped or changed under stall");

	// every taken word yields a result on the next cycle
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> out_valid)
		else $error("no result one cycle after input word");

	// an empty result register never blocks input
	a_no_block: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input blocked with empty output");

	// color is off exactly when powered down
	a_color: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_data.power_on == 1'b0) == (out_data.status_color == COLOR_OFF))
		else $error("status color disagrees with power state");

	// toggle events agree with the resulting power state
	a_toggle: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (out_data.event_code == EV_POWER_ON ||
		              out_data.event_code == EV_POWER_OFF)
		|-> out_data.power_on == (out_data.event_code == EV_POWER_ON))
		else $error("power event does not match power state");

endmodule

bind button_press_power_controller bpc_checker u_bpc_checker (.*);
